@@ rtl/core/org_pkg.sv @@
// ----------------------------------------------------------------------------
// org_pkg: shared types and constants for the order routing gate
// Action, decision and venue state codes, controller states and the command
// and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package org_pkg;

   localparam int ACTION_W   = 3;
   localparam int SYMBOL_W   = 32;
   localparam int VENUE_W    = 8;
   localparam int STATE_W    = 2;
   localparam int QTY_W      = 32;
   localparam int DECISION_W = 3;
   localparam int WIDE_W     = 64;
   localparam int EPOCH_W    = 32;
   localparam int CWIDTH_W   = 6;
   localparam int VCOUNT_W   = 5;
   localparam int CTR_W      = 49;
   localparam int CWIDTH_MAX = 48;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ROUTE      = 3'd0,
      ACT_MAP        = 3'd1,
      ACT_UNMAP      = 3'd2,
      ACT_SET_STATE  = 3'd3,
      ACT_LOGON      = 3'd4,
      ACT_DISCONNECT = 3'd5,
      ACT_QUERY      = 3'd6,
      ACT_LOOKUP     = 3'd7
   } action_type;

   typedef enum logic [DECISION_W-1:0] {
      DEC_ROUTED     = 3'd0,
      DEC_NOT_CONFIG = 3'd1,
      DEC_BAD_ORDER  = 3'd2,
      DEC_NO_ROUTE   = 3'd3,
      DEC_VENUE_DOWN = 3'd4,
      DEC_DRAINING   = 3'd5,
      DEC_IDS_OUT    = 3'd6
   } decision_type;

   localparam logic [STATE_W-1:0] VST_DOWN  = 2'd0;
   localparam logic [STATE_W-1:0] VST_UP    = 2'd1;
   localparam logic [STATE_W-1:0] VST_DRAIN = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_EPOCH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CWIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VCOUNT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic load;      // capture item, clear search
      logic scan;      // examine one table entry
      logic exec;      // decide and update state
      logic out_load;  // result register takes the decision
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
   } dp_status_type;

endpackage

@@ rtl/core/org_if.sv @@
// ----------------------------------------------------------------------------
// org_req_if / org_rsp_if / org_csr_if: valid-ready channels
// Request, response and register write channels of the routing gate.
// ----------------------------------------------------------------------------
interface org_req_if;
   logic                          valid;
   logic                          ready;
   logic [org_pkg::ACTION_W-1:0]  action;
   logic [org_pkg::SYMBOL_W-1:0]  symbol;
   logic [org_pkg::VENUE_W-1:0]   venue;
   logic [org_pkg::STATE_W-1:0]   new_state;
   logic signed [org_pkg::QTY_W-1:0] quantity;
   logic                          liquidating;
   modport source (output valid, action, symbol, venue, new_state, quantity,
                   liquidating, input ready);
   modport sink   (input valid, action, symbol, venue, new_state, quantity,
                   liquidating, output ready);
endinterface

interface org_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [org_pkg::DECISION_W-1:0]  decision;
   logic                            ok;
   logic [org_pkg::VENUE_W-1:0]     routed_venue;
   logic [org_pkg::WIDE_W-1:0]      order_id;
   logic [org_pkg::WIDE_W-1:0]      sequence_out;
   logic [org_pkg::WIDE_W-1:0]      routed_total;
   logic [org_pkg::STATE_W-1:0]     state_out;
   modport source (output valid, decision, ok, routed_venue, order_id,
                   sequence_out, routed_total, state_out, input ready);
   modport sink   (input valid, decision, ok, routed_venue, order_id,
                   sequence_out, routed_total, state_out, output ready);
endinterface

interface org_csr_if;
   logic                            valid;
   logic                            ready;
   logic [org_pkg::CSR_IDX_W-1:0]   index;
   logic [org_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/org_ctrl.sv @@
// ----------------------------------------------------------------------------
// org_ctrl: sequencing controller
// Steps each item through capture, table scan, execute and output hand-off.
// ----------------------------------------------------------------------------
module org_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic                   out_busy,
   input  org_pkg::dp_status_type status,
   output org_pkg::dp_cmd_type    cmd
);
   import org_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (in_valid) state_in = ST_SCAN;
         ST_SCAN: if (status.scan_done) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_OUT;
         ST_OUT:  if (!out_busy) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      in_ready     = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            cmd.load = in_valid;
         end
         ST_SCAN: cmd.scan = 1'b1;
         ST_EXEC: cmd.exec = 1'b1;
         ST_OUT:  cmd.out_load = !out_busy;
         default: ;
      endcase
   end

endmodule

@@ rtl/core/org_dpath.sv @@
// ----------------------------------------------------------------------------
// org_dpath: routing datapath
// Symbol table memory with sequential scan, venue state and counters, ID
// counter and the decision logic.
// ----------------------------------------------------------------------------
module org_dpath #(
   parameter int MAX_VENUES     = 16,
   parameter int SYMBOL_ENTRIES = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  org_pkg::dp_cmd_type           cmd,
   output org_pkg::dp_status_type        status,
   input  logic [org_pkg::ACTION_W-1:0]  in_action,
   input  logic [org_pkg::SYMBOL_W-1:0]  in_symbol,
   input  logic [org_pkg::VENUE_W-1:0]   in_venue,
   input  logic [org_pkg::STATE_W-1:0]   in_new_state,
   input  logic [org_pkg::QTY_W-1:0]     in_quantity,
   input  logic                          in_liquidating,
   input  logic [org_pkg::EPOCH_W-1:0]   epoch,
   input  logic [org_pkg::CWIDTH_W-1:0]  cwidth,
   input  logic [org_pkg::VCOUNT_W-1:0]  vcount,
   output logic [org_pkg::DECISION_W-1:0] r_decision,
   output logic                          r_ok,
   output logic [org_pkg::VENUE_W-1:0]   r_venue,
   output logic [org_pkg::WIDE_W-1:0]    r_order_id,
   output logic [org_pkg::WIDE_W-1:0]    r_sequence,
   output logic [org_pkg::WIDE_W-1:0]    r_total,
   output logic [org_pkg::STATE_W-1:0]   r_state
);
   import org_pkg::*;

   localparam int SW = (SYMBOL_ENTRIES > 1) ? $clog2(SYMBOL_ENTRIES) : 1;
   localparam int VW = (MAX_VENUES > 1) ? $clog2(MAX_VENUES) : 1;

   // symbol table: valid bits in flops, symbol and venue in memory
   logic [SYMBOL_W-1:0] sym_mem [SYMBOL_ENTRIES];
   logic [VENUE_W-1:0]  ven_mem [SYMBOL_ENTRIES];
   logic [SYMBOL_ENTRIES-1:0] valid_ff;

   logic [STATE_W-1:0] vstate_ff [MAX_VENUES];
   logic [WIDE_W-1:0]  vseq_ff   [MAX_VENUES];
   logic [WIDE_W-1:0]  vcnt_ff   [MAX_VENUES];
   logic [CTR_W-1:0]   idctr_ff;

   // captured item
   logic [ACTION_W-1:0] act_ff;
   logic [SYMBOL_W-1:0] sym_ff;
   logic [VENUE_W-1:0]  ven_ff;
   logic [STATE_W-1:0]  nst_ff;
   logic [QTY_W-1:0]    qty_ff;
   logic                liq_ff;

   // scan
   logic [SW:0]         addr_ff;
   logic                rd_pend_ff;
   logic [SW-1:0]       rd_addr_ff;
   logic [SYMBOL_W-1:0] rd_sym_ff;
   logic [VENUE_W-1:0]  rd_ven_ff;
   logic                rd_valid_ff;
   logic                found_ff, free_ff;
   logic [SW-1:0]       hit_ff, free_idx_ff;
   logic [VENUE_W-1:0]  hit_ven_ff;

   // staged results
   logic [DECISION_W-1:0] dec_ff;
   logic                  ok_ff;
   logic [VENUE_W-1:0]    rven_ff;
   logic [WIDE_W-1:0]     oid_ff, seq_ff, tot_ff;
   logic [STATE_W-1:0]    rst_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= in_action;
         sym_ff <= in_symbol;
         ven_ff <= in_venue;
         nst_ff <= in_new_state;
         qty_ff <= in_quantity;
         liq_ff <= in_liquidating;
      end
   end

   // scan: one read per cycle, compared against the item in the cycle after the read
   logic rd_hit;
   assign rd_hit = rd_pend_ff && rd_valid_ff && (rd_sym_ff == sym_ff);
   assign status.scan_done = (addr_ff == (SW+1)'(SYMBOL_ENTRIES)) && !rd_pend_ff;

   always_ff @(posedge clock) begin
      if (cmd.scan && addr_ff != (SW+1)'(SYMBOL_ENTRIES)) begin
         rd_sym_ff   <= sym_mem[addr_ff[SW-1:0]];
         rd_ven_ff   <= ven_mem[addr_ff[SW-1:0]];
         rd_valid_ff <= valid_ff[addr_ff[SW-1:0]];
         rd_addr_ff  <= addr_ff[SW-1:0];
      end
      if (cmd.scan && rd_hit && !found_ff) begin
         hit_ff     <= rd_addr_ff;
         hit_ven_ff <= rd_ven_ff;
      end
      if (cmd.scan && rd_pend_ff && !rd_valid_ff && !free_ff) begin
         free_idx_ff <= rd_addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         addr_ff    <= '0;
         rd_pend_ff <= 1'b0;
         found_ff   <= 1'b0;
         free_ff    <= 1'b0;
      end else if (cmd.scan) begin
         rd_pend_ff <= (addr_ff != (SW+1)'(SYMBOL_ENTRIES));
         if (addr_ff != (SW+1)'(SYMBOL_ENTRIES)) addr_ff <= addr_ff + 1'b1;
         if (rd_hit) found_ff <= 1'b1;
         if (rd_pend_ff && !rd_valid_ff) free_ff <= 1'b1;
      end
   end

   // venue checks
   logic [VCOUNT_W-1:0] vlim;
   assign vlim = (32'(vcount) > MAX_VENUES) ? VCOUNT_W'(MAX_VENUES) : vcount;

   function automatic logic venue_valid(input logic [VENUE_W-1:0] v,
                                        input logic [VCOUNT_W-1:0] lim);
      return (v != '0) && ({1'b0, v} <= 9'(lim));
   endfunction

   logic          in_ok, hv_ok;
   logic [VW-1:0] in_vi, hv_vi;
   logic [VENUE_W-1:0] in_vm1, hv_vm1;
   assign in_ok  = venue_valid(ven_ff, vlim);
   assign hv_ok  = venue_valid(hit_ven_ff, vlim);
   assign in_vm1 = ven_ff - 1'b1;
   assign hv_vm1 = hit_ven_ff - 1'b1;
   assign in_vi  = in_vm1[VW-1:0];
   assign hv_vi  = hv_vm1[VW-1:0];

   logic configured;
   logic [WIDE_W-1:0] epoch_sh, cmax;
   assign epoch_sh = {32'd0, epoch} << cwidth;
   assign cmax     = (64'd1 << cwidth) - 64'd1;
   assign configured = (cwidth >= 6'd1) && (32'(cwidth) <= CWIDTH_MAX)
                       && ((epoch_sh >> cwidth) == {32'd0, epoch});

   logic [STATE_W-1:0] hst;
   assign hst = vstate_ff[hv_vi];

   logic [DECISION_W-1:0] rdec;
   always_comb begin
      if (!configured) rdec = DEC_NOT_CONFIG;
      else if (qty_ff == '0 || qty_ff[QTY_W-1]) rdec = DEC_BAD_ORDER;
      else if (!found_ff) rdec = DEC_NO_ROUTE;
      else if (!hv_ok || hst == VST_DOWN) rdec = DEC_VENUE_DOWN;
      else if (hst == VST_DRAIN && !liq_ff) rdec = DEC_DRAINING;
      else if ({15'd0, idctr_ff} > cmax) rdec = DEC_IDS_OUT;
      else rdec = DEC_ROUTED;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         idctr_ff <= '0;
         for (int i = 0; i < MAX_VENUES; i++) begin
            vstate_ff[i] <= VST_DOWN;
            vseq_ff[i]   <= '0;
            vcnt_ff[i]   <= '0;
         end
      end else if (cmd.exec) begin
         case (action_type'(act_ff))
            ACT_ROUTE: if (rdec == DEC_ROUTED) begin
               idctr_ff       <= idctr_ff + 1'b1;
               vseq_ff[hv_vi] <= vseq_ff[hv_vi] + 64'd1;
               vcnt_ff[hv_vi] <= vcnt_ff[hv_vi] + 64'd1;
            end
            ACT_MAP: if (in_ok && (found_ff || free_ff))
               valid_ff[found_ff ? hit_ff : free_idx_ff] <= 1'b1;
            ACT_UNMAP: if (found_ff) valid_ff[hit_ff] <= 1'b0;
            ACT_SET_STATE: if (in_ok && nst_ff <= VST_DRAIN) vstate_ff[in_vi] <= nst_ff;
            ACT_LOGON: if (in_ok) begin
               vseq_ff[in_vi]   <= '0;
               vstate_ff[in_vi] <= VST_UP;
            end
            ACT_DISCONNECT: if (in_ok) vstate_ff[in_vi] <= VST_DOWN;
            default: ;
         endcase
      end
   end

   // table memory write
   always_ff @(posedge clock) begin
      if (cmd.exec && act_ff == ACT_MAP && in_ok && (found_ff || free_ff)) begin
         sym_mem[found_ff ? hit_ff : free_idx_ff] <= sym_ff;
         ven_mem[found_ff ? hit_ff : free_idx_ff] <= ven_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         dec_ff  <= DEC_ROUTED;
         ok_ff   <= 1'b0;
         rven_ff <= '0;
         oid_ff  <= '0;
         seq_ff  <= '0;
         tot_ff  <= '0;
         rst_ff  <= VST_DOWN;
         case (action_type'(act_ff))
            ACT_ROUTE: begin
               dec_ff <= rdec;
               if (configured && rdec != DEC_BAD_ORDER && found_ff)
                  rven_ff <= hit_ven_ff;
               if (rdec == DEC_ROUTED) begin
                  ok_ff  <= 1'b1;
                  oid_ff <= epoch_sh | {15'd0, idctr_ff};
                  seq_ff <= vseq_ff[hv_vi] + 64'd1;
               end
            end
            ACT_MAP:       ok_ff <= in_ok && (found_ff || free_ff);
            ACT_UNMAP:     ok_ff <= found_ff;
            ACT_SET_STATE: ok_ff <= in_ok && nst_ff <= VST_DRAIN;
            ACT_LOGON, ACT_DISCONNECT: ok_ff <= in_ok;
            ACT_QUERY: if (in_ok) begin
               ok_ff   <= 1'b1;
               rven_ff <= ven_ff;
               seq_ff  <= vseq_ff[in_vi];
               tot_ff  <= vcnt_ff[in_vi];
               rst_ff  <= vstate_ff[in_vi];
            end
            default: if (found_ff) begin
               ok_ff   <= 1'b1;
               rven_ff <= hit_ven_ff;
            end
         endcase
      end
   end

   assign r_decision = dec_ff;
   assign r_ok       = ok_ff;
   assign r_venue    = rven_ff;
   assign r_order_id = oid_ff;
   assign r_sequence = seq_ff;
   assign r_total    = tot_ff;
   assign r_state    = rst_ff;

endmodule

@@ rtl/core/order_route_gate.sv @@
// ----------------------------------------------------------------------------
// order_route_gate: order routing gate
// Symbol-to-venue routing with per-venue session state and ID issue.
// ----------------------------------------------------------------------------
// Timing: the table scan reads one entry per cycle from a single memory port;
//   one item is in flight at a time, the next accepted only once the result
//   has gone into the output register, so output stalls hold off new items.
// Reset: synchronous; clears venue states, counters, ID counter, table valid
//   bits, the config registers and the response valid; no clearing pass.
module order_route_gate #(
   parameter int MAX_VENUES     = 16,
   parameter int SYMBOL_ENTRIES = 256
) (
   input logic        clock,
   input logic        reset,
   org_req_if.sink    req,
   org_rsp_if.source  rsp,
   org_csr_if.sink    csr
);
   import org_pkg::*;

   logic [EPOCH_W-1:0]  epoch_ff;
   logic [CWIDTH_W-1:0] cwidth_ff;
   logic [VCOUNT_W-1:0] vcount_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff  <= '0;
         cwidth_ff <= '0;
         vcount_ff <= '0;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_EPOCH:  epoch_ff  <= csr.data;
            CSR_CWIDTH: cwidth_ff <= csr.data[CWIDTH_W-1:0];
            CSR_VCOUNT: vcount_ff <= csr.data[VCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          out_busy;

   logic [DECISION_W-1:0] d_dec;
   logic                  d_ok;
   logic [VENUE_W-1:0]    d_ven;
   logic [WIDE_W-1:0]     d_oid, d_seq, d_tot;
   logic [STATE_W-1:0]    d_st;

   org_ctrl u_ctrl (
      .clock, .reset,
      .in_valid (req.valid),
      .in_ready (req.ready),
      .out_busy,
      .status,
      .cmd
   );

   org_dpath #(.MAX_VENUES(MAX_VENUES), .SYMBOL_ENTRIES(SYMBOL_ENTRIES)) u_dpath (
      .clock, .reset, .cmd, .status,
      .in_action      (req.action),
      .in_symbol      (req.symbol),
      .in_venue       (req.venue),
      .in_new_state   (req.new_state),
      .in_quantity    (req.quantity),
      .in_liquidating (req.liquidating),
      .epoch (epoch_ff), .cwidth (cwidth_ff), .vcount (vcount_ff),
      .r_decision (d_dec), .r_ok (d_ok), .r_venue (d_ven),
      .r_order_id (d_oid), .r_sequence (d_seq), .r_total (d_tot),
      .r_state (d_st)
   );

   // output register
   logic rsp_valid_ff;
   assign out_busy  = rsp_valid_ff && !rsp.ready;
   assign rsp.valid = rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp.decision     <= d_dec;
         rsp.ok           <= d_ok;
         rsp.routed_venue <= d_ven;
         rsp.order_id     <= d_oid;
         rsp.sequence_out <= d_seq;
         rsp.routed_total <= d_tot;
         rsp.state_out    <= d_st;
      end
   end

   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.decision != DEC_ROUTED |-> rsp.order_id == '0)
      else $error("order id on rejected item");
   a_ok_route: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req.ready)
      else $error("request taken while busy");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.scan, cmd.exec, cmd.out_load}))
      else $error("overlapping datapath commands");

endmodule

@@ verif/order_route_gate_test.sv @@
// ----------------------------------------------------------------------------
// order_route_gate_test: self-checking bench for the order routing gate
// Walks a table of directed items, then random order flow in several register
// settings and a table fill, predicting every response and comparing it field by field.
// ----------------------------------------------------------------------------
module order_route_gate_test;
   timeunit 1ns;
   timeprecision 1ps;
   import org_pkg::*;

   localparam int NV    = 16;
   localparam int NSYM  = 256;
   localparam int LAT   = NSYM + 8;

   typedef struct packed {
      logic [DECISION_W-1:0] decision;
      logic                  ok;
      logic [VENUE_W-1:0]    routed_venue;
      logic [WIDE_W-1:0]     order_id;
      logic [WIDE_W-1:0]     sequence_out;
      logic [WIDE_W-1:0]     routed_total;
      logic [STATE_W-1:0]    state_out;
   } gate_result_type;

   typedef struct packed {
      action_type           action;
      logic [SYMBOL_W-1:0]  symbol;
      logic [VENUE_W-1:0]   venue;
      logic [STATE_W-1:0]   new_state;
      logic [QTY_W-1:0]     quantity;
      logic                 liquidating;
   } order_item_type;

   typedef struct {
      order_item_type  item;
      bit              fixed;
      gate_result_type res;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;

   org_req_if req();
   org_rsp_if rsp();
   org_csr_if csr();

   order_route_gate u_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
                           .csr(csr));

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // predictor state
   logic                 tab_valid [NSYM];
   logic [SYMBOL_W-1:0]  tab_sym [NSYM];
   logic [VENUE_W-1:0]   tab_ven [NSYM];
   logic [STATE_W-1:0]   ven_state [NV];
   logic [WIDE_W-1:0]    ven_seq [NV];
   logic [WIDE_W-1:0]    ven_routed [NV];
   logic [CTR_W-1:0]     id_ctr;
   logic [EPOCH_W-1:0]   epoch_r;
   logic [CWIDTH_W-1:0]  cwidth_r;
   logic [VCOUNT_W-1:0]  vcount_r;

   gate_result_type pending_results[$];
   int errors = 0;
   int n_checked = 0;
   int n_routed = 0;
   int send_idle = 15, recv_idle = 68;
   logic [SYMBOL_W-1:0] sym_pool[8];

   task automatic report(input string what, input logic [63:0] got,
                         input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      errors++;
   endtask

   function automatic bit venue_in_use(input logic [VENUE_W-1:0] v);
      int n;
      n = (vcount_r > NV) ? NV : vcount_r;
      return v != 0 && v <= n;
   endfunction

   function automatic int find_entry(input logic [SYMBOL_W-1:0] s);
      for (int i = 0; i < NSYM; i++)
         if (tab_valid[i] && tab_sym[i] == s) return i;
      return -1;
   endfunction

   function automatic gate_result_type predict_gate(input order_item_type it);
      gate_result_type r;
      int e;
      logic [VENUE_W-1:0] mv;
      logic [63:0] cmax;
      r = '0;
      case (it.action)
         ACT_ROUTE: begin
            if (cwidth_r < 1 || cwidth_r > CWIDTH_MAX ||
                (64'(epoch_r) >> (64 - cwidth_r)) != 0) begin
               r.decision = DEC_NOT_CONFIG;
            end else if (it.quantity == 0 || it.quantity[QTY_W-1]) begin
               r.decision = DEC_BAD_ORDER;
            end else begin
               e = find_entry(it.symbol);
               if (e < 0) begin
                  r.decision = DEC_NO_ROUTE;
               end else begin
                  mv = tab_ven[e];
                  r.routed_venue = mv;
                  cmax = (64'd1 << cwidth_r) - 64'd1;
                  if (!venue_in_use(mv) || ven_state[mv-1] == VST_DOWN)
                     r.decision = DEC_VENUE_DOWN;
                  else if (ven_state[mv-1] == VST_DRAIN && !it.liquidating)
                     r.decision = DEC_DRAINING;
                  else if (64'(id_ctr) > cmax)
                     r.decision = DEC_IDS_OUT;
                  else begin
                     r.order_id = (64'(epoch_r) << cwidth_r) | 64'(id_ctr);
                     id_ctr++;
                     ven_seq[mv-1]++;
                     ven_routed[mv-1]++;
                     r.sequence_out = ven_seq[mv-1];
                     r.decision = DEC_ROUTED;
                     r.ok = 1;
                  end
               end
            end
         end
         ACT_MAP: begin
            if (venue_in_use(it.venue)) begin
               e = find_entry(it.symbol);
               if (e < 0)
                  for (int i = NSYM - 1; i >= 0; i--)
                     if (!tab_valid[i]) e = i;
               if (e >= 0) begin
                  tab_valid[e] = 1;
                  tab_sym[e] = it.symbol;
                  tab_ven[e] = it.venue;
                  r.ok = 1;
               end
            end
         end
         ACT_UNMAP: begin
            e = find_entry(it.symbol);
            if (e >= 0) begin
               tab_valid[e] = 0;
               r.ok = 1;
            end
         end
         ACT_SET_STATE: begin
            if (venue_in_use(it.venue) && it.new_state <= VST_DRAIN) begin
               ven_state[it.venue-1] = it.new_state;
               r.ok = 1;
            end
         end
         ACT_LOGON: begin
            if (venue_in_use(it.venue)) begin
               ven_seq[it.venue-1] = 0;
               ven_state[it.venue-1] = VST_UP;
               r.ok = 1;
            end
         end
         ACT_DISCONNECT: begin
            if (venue_in_use(it.venue)) begin
               ven_state[it.venue-1] = VST_DOWN;
               r.ok = 1;
            end
         end
         ACT_QUERY: begin
            if (venue_in_use(it.venue)) begin
               r.ok = 1;
               r.routed_venue = it.venue;
               r.sequence_out = ven_seq[it.venue-1];
               r.routed_total = ven_routed[it.venue-1];
               r.state_out = ven_state[it.venue-1];
            end
         end
         default: begin
            e = find_entry(it.symbol);
            if (e >= 0) begin
               r.ok = 1;
               r.routed_venue = tab_ven[e];
            end
         end
      endcase
      return r;
   endfunction

   initial begin
      req.valid = 0; req.action = ACT_ROUTE; req.symbol = 0; req.venue = 0;
      req.new_state = 0; req.quantity = 0; req.liquidating = 0;
      rsp.ready = 0;
      csr.valid = 0; csr.index = CSR_EPOCH; csr.data = 0;
      for (int i = 0; i < NSYM; i++) tab_valid[i] = 0;
      for (int i = 0; i < NV; i++) begin
         ven_state[i] = VST_DOWN; ven_seq[i] = 0; ven_routed[i] = 0;
      end
      id_ctr = 0; epoch_r = 0; cwidth_r = 0; vcount_r = 0;
   end

   // response side: random stall, check against oldest expectation
   always @(posedge clock) begin
      gate_result_type want;
      if (reset) begin
         rsp.ready <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (pending_results.size() == 0) begin
               report("unexpected item", 64'd0, 64'd0);
            end else begin
               want = pending_results.pop_front();
               n_checked++;
               if (rsp.decision !== want.decision)
                  report("decision", 64'(rsp.decision), 64'(want.decision));
               if (rsp.ok !== want.ok) report("ok", 64'(rsp.ok), 64'(want.ok));
               if (rsp.routed_venue !== want.routed_venue)
                  report("routed_venue", 64'(rsp.routed_venue),
                         64'(want.routed_venue));
               if (rsp.order_id !== want.order_id)
                  report("order_id", rsp.order_id, want.order_id);
               if (rsp.sequence_out !== want.sequence_out)
                  report("sequence_out", rsp.sequence_out, want.sequence_out);
               if (rsp.routed_total !== want.routed_total)
                  report("routed_total", rsp.routed_total, want.routed_total);
               if (rsp.state_out !== want.state_out)
                  report("state_out", 64'(rsp.state_out), 64'(want.state_out));
            end
         end
         rsp.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr.valid <= 1; csr.index <= idx; csr.data <= val;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 0;
      @(posedge clock);
      if (idx == CSR_EPOCH) epoch_r = val;
      else if (idx == CSR_CWIDTH) cwidth_r = val[CWIDTH_W-1:0];
      else if (idx == CSR_VCOUNT) vcount_r = val[VCOUNT_W-1:0];
   endtask

   // send one item; a fixed row's expectation must also match the predictor
   task automatic send_item(input order_item_type it, input bit fixed,
                            input gate_result_type typed);
      gate_result_type p;
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1;
      req.action <= it.action; req.symbol <= it.symbol; req.venue <= it.venue;
      req.new_state <= it.new_state; req.quantity <= it.quantity;
      req.liquidating <= it.liquidating;
      do @(posedge clock); while (!req.ready);
      p = predict_gate(it);
      if (fixed && p !== typed)
         report("directed table row", 64'({p.decision, p.ok, p.routed_venue}),
                64'({typed.decision, typed.ok, typed.routed_venue}));
      if (p.decision == DEC_ROUTED && it.action == ACT_ROUTE) n_routed++;
      pending_results.insert(pending_results.size(), fixed ? typed : p);
   endtask

   task automatic drain_all();
      req.valid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LAT) @(posedge clock);
   endtask

   function automatic order_item_type mk(input action_type a,
                                         input logic [SYMBOL_W-1:0] s,
                                         input logic [VENUE_W-1:0] v,
                                         input logic [STATE_W-1:0] ns,
                                         input logic [QTY_W-1:0] q,
                                         input logic l);
      order_item_type it;
      it.action = a; it.symbol = s; it.venue = v; it.new_state = ns;
      it.quantity = q; it.liquidating = l;
      return it;
   endfunction

   function automatic gate_result_type rs(input decision_type d, input logic ok,
                                          input logic [VENUE_W-1:0] v);
      gate_result_type r;
      r = '0; r.decision = d; r.ok = ok; r.routed_venue = v;
      return r;
   endfunction

   function automatic order_item_type random_item();
      order_item_type it;
      int k;
      it.new_state = 2'($urandom_range(3));
      it.quantity = $urandom;
      it.liquidating = 1'($urandom_range(1));
      k = $urandom_range(99);
      it.symbol = (k < 85) ? sym_pool[$urandom_range(7)] : $urandom;
      it.venue = (k < 90) ? 8'($urandom_range(17)) : 8'($urandom);
      if (k < 70) it.quantity = (k < 60) ? $urandom_range(1000, 1) : $urandom;
      k = $urandom_range(99);
      if (k < 45) it.action = ACT_ROUTE;
      else it.action = action_type'($urandom_range(7));
      return it;
   endfunction

   stim_row_type directed[$];

   function automatic void add_row(input order_item_type it, input bit fixed,
                                   input gate_result_type res);
      stim_row_type row;
      row.item = it; row.fixed = fixed; row.res = res;
      directed.insert(directed.size(), row);
   endfunction

   initial begin
      gate_result_type none;
      none = '0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // after reset: not configured, empty table, no venues
      add_row(mk(ACT_ROUTE, 32'h1, 1, 0, 5, 0), 1, rs(DEC_NOT_CONFIG, 0, 0));
      add_row(mk(ACT_MAP, 32'h1, 1, 0, 0, 0), 1, rs(DEC_ROUTED, 0, 0));
      add_row(mk(ACT_QUERY, 0, 0, 0, 0, 0), 1, none);
      add_row(mk(ACT_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0, 0), 1, none);
      add_row(mk(ACT_UNMAP, 32'h1, 0, 0, 0, 0), 1, none);
      foreach (directed[i]) send_item(directed[i].item, 1, directed[i].res);
      drain_all();
      directed.delete();

      csr_write(CSR_EPOCH, 32'hFFFF_FFFF);
      csr_write(CSR_CWIDTH, 32);
      csr_write(CSR_VCOUNT, 31);  // above the venue limit, acts as the limit
      add_row(mk(ACT_ROUTE, 32'h1, 0, 0, 0, 0), 1, rs(DEC_BAD_ORDER, 0, 0));
      add_row(mk(ACT_ROUTE, 32'h1, 0, 0, 32'h8000_0000, 0), 1,
              rs(DEC_BAD_ORDER, 0, 0));
      add_row(mk(ACT_ROUTE, 32'h0, 0, 0, 32'h7FFF_FFFF, 1), 1,
              rs(DEC_NO_ROUTE, 0, 0));
      add_row(mk(ACT_MAP, 32'h0, 16, 0, 0, 0), 1, rs(DEC_ROUTED, 1, 0));
      add_row(mk(ACT_MAP, 32'hFFFF_FFFF, 17, 0, 0, 0), 1, none);
      add_row(mk(ACT_MAP, 32'hFFFF_FFFF, 255, 0, 0, 0), 1, none);
      add_row(mk(ACT_ROUTE, 32'h0, 0, 0, 1, 0), 1, rs(DEC_VENUE_DOWN, 0, 16));
      add_row(mk(ACT_SET_STATE, 0, 16, 3, 0, 0), 1, none);
      add_row(mk(ACT_SET_STATE, 0, 16, VST_DRAIN, 0, 0), 1, rs(DEC_ROUTED, 1, 0));
      add_row(mk(ACT_ROUTE, 32'h0, 0, 0, 9, 0), 1, rs(DEC_DRAINING, 0, 16));
      add_row(mk(ACT_ROUTE, 32'h0, 0, 0, 9, 1), 0, none);
      add_row(mk(ACT_LOGON, 0, 16, 0, 0, 0), 1, rs(DEC_ROUTED, 1, 0));
      add_row(mk(ACT_ROUTE, 32'h0, 0, 0, 1, 0), 0, none);
      add_row(mk(ACT_QUERY, 0, 16, 0, 0, 0), 0, none);
      add_row(mk(ACT_MAP, 32'h0, 1, 0, 0, 0), 1, rs(DEC_ROUTED, 1, 0));
      add_row(mk(ACT_LOOKUP, 32'h0, 0, 0, 0, 0), 1, rs(DEC_ROUTED, 1, 1));
      add_row(mk(ACT_DISCONNECT, 0, 0, 0, 0, 0), 1, none);
      add_row(mk(ACT_DISCONNECT, 0, 16, 0, 0, 0), 1, rs(DEC_ROUTED, 1, 0));
      add_row(mk(ACT_UNMAP, 32'h0, 0, 0, 0, 0), 1, rs(DEC_ROUTED, 1, 0));
      foreach (directed[i]) send_item(directed[i].item, directed[i].fixed,
                                      directed[i].res);
      drain_all();

      // random phases over several register settings
      for (int ph = 0; ph < 6; ph++) begin
         send_idle = (ph < 2) ? 15 : (ph < 4) ? 68 : 0;
         recv_idle = (ph < 2) ? 68 : (ph < 4) ? 15 : 0;
         case (ph)
            0: begin csr_write(CSR_CWIDTH, 1); csr_write(CSR_EPOCH, 0);
                     csr_write(CSR_VCOUNT, 4); end
            1: begin csr_write(CSR_CWIDTH, 48); csr_write(CSR_EPOCH, 32'hFFFF);
                     csr_write(CSR_VCOUNT, 16); end
            2: begin csr_write(CSR_CWIDTH, 49); csr_write(CSR_VCOUNT, 1); end
            3: begin csr_write(CSR_CWIDTH, 33); csr_write(CSR_EPOCH, 32'h7FFF_FFFF);
                     csr_write(CSR_VCOUNT, 3); end
            4: begin csr_write(CSR_CWIDTH, 63); csr_write(CSR_VCOUNT, 0); end
            default: begin csr_write(CSR_CWIDTH, 40);
                     csr_write(CSR_EPOCH, $urandom); csr_write(CSR_VCOUNT, 8); end
         endcase
         for (int i = 0; i < 8; i++) sym_pool[i] = (ph == 5) ? $urandom : 32'h10 * i;
         // bring venues up and map the pool so routes get deep
         for (int v = 1; v <= 4; v++)
            send_item(mk(ACT_LOGON, 0, 8'(v), 0, 0, 0), 0, none);
         for (int i = 0; i < 8; i++)
            send_item(mk(ACT_MAP, sym_pool[i], 8'($urandom_range(4, 1)), 0, 0, 0),
                      0, none);
         repeat (8) send_item(random_item(), 0, none);
         drain_all();
      end

      // fill the table, then a new symbol must be refused
      csr_write(CSR_VCOUNT, 2);
      for (int i = 0; i < NSYM; i++)
         send_item(mk(ACT_MAP, 32'h100 + i, 1, 0, 0, 0), 0, none);
      send_item(mk(ACT_MAP, 32'hABCD, 2, 0, 0, 0), 1, none);
      send_item(mk(ACT_MAP, 32'h100, 2, 0, 0, 0), 1, rs(DEC_ROUTED, 1, 0));
      drain_all();

      $display("checked %0d responses, %0d orders routed, six register settings",
               n_checked, n_routed);
      if (errors == 0)
         $display("PASS order_route_gate");
      else
         $display("FAIL order_route_gate");
      $finish;
   end

   initial begin
      #60ms;
      $display("FAIL order_route_gate");
      $finish;
   end

endmodule

@@ order_route_gate.f @@
rtl/core/org_pkg.sv
rtl/core/org_if.sv
rtl/core/org_ctrl.sv
rtl/core/org_dpath.sv
rtl/core/order_route_gate.sv
verif/order_route_gate_test.sv
